// ===== src/hspfd_pkg.sv =====
package hspfd_pkg;

   localparam int COUNT_BITS  = 16;
   localparam int PULSE_BITS  = 16;
   localparam int WIDTH_BITS  = (COUNT_BITS < PULSE_BITS) ? COUNT_BITS : PULSE_BITS;
   localparam int DATA_BITS   = 40;
   localparam int DATA_PULSES = 80;
   localparam int IDX_BITS    = $clog2(DATA_PULSES);
   localparam int BYTE_BITS   = 8;
   localparam int STATUS_BITS = 3;

   localparam logic OP_START = 1'b0;
   localparam logic OP_PULSE = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK               = 3'd0,
      STATUS_NOT_READY        = 3'd1,
      STATUS_RESPONSE_TIMEOUT = 3'd2,
      STATUS_BIT_TIMEOUT      = 3'd3,
      STATUS_CHECKSUM         = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'b0001,
      PH_RESP_LOW  = 4'b0010,
      PH_RESP_HIGH = 4'b0100,
      PH_DATA      = 4'b1000
   } phase_type;

   typedef struct packed {
      logic                  operation;
      logic                  line_level;
      logic [PULSE_BITS-1:0] pulse_count;
   } item_type;

   typedef struct packed {
      logic                 produce;
      logic [DATA_BITS-1:0] frame_bytes;
      status_type           status;
   } result_type;

   function automatic logic checksum_ok(input logic [DATA_BITS-1:0] frame);
      logic [BYTE_BITS+1:0] sum;
      sum = {2'b00, frame[39:32]} + {2'b00, frame[31:24]}
          + {2'b00, frame[23:16]} + {2'b00, frame[15:8]};
      return sum[BYTE_BITS-1:0] == frame[BYTE_BITS-1:0];
   endfunction

endpackage

// ===== src/hspfd_req_if.sv =====
interface hspfd_req_if;
   logic                             valid;
   logic                             ready;
   logic                             operation;
   logic                             line_level;
   logic [hspfd_pkg::PULSE_BITS-1:0] pulse_count;

   modport source (output valid, output operation, output line_level, output pulse_count,
                   input ready);
   modport sink (input valid, input operation, input line_level, input pulse_count,
                 output ready);
endinterface

// ===== src/hspfd_rsp_if.sv =====
interface hspfd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [hspfd_pkg::DATA_BITS-1:0]   frame_bytes;
   logic [hspfd_pkg::STATUS_BITS-1:0] status;

   modport source (output valid, output frame_bytes, output status, input ready);
   modport sink (input valid, input frame_bytes, input status, output ready);
endinterface

// ===== src/hspfd_core.sv =====
module hspfd_core (
   input  logic                  clock,
   input  logic                  reset,
   input  hspfd_pkg::item_type   item,
   input  logic                  process,
   output hspfd_pkg::result_type result
);

   hspfd_pkg::phase_type                phase_ff, phase_in;
   logic [hspfd_pkg::IDX_BITS-1:0]      idx_ff, idx_in;
   logic [hspfd_pkg::WIDTH_BITS-1:0]    held_ff, held_in;
   logic [hspfd_pkg::DATA_BITS-1:0]     shifter_ff, shifter_in;
   logic                                timeout_ff, timeout_in;
   logic [hspfd_pkg::WIDTH_BITS-1:0]    width;
   logic                                width_zero;
   logic                                last_pulse;

   assign width      = item.pulse_count[hspfd_pkg::WIDTH_BITS-1:0];
   assign width_zero = (width == '0);
   assign last_pulse = (idx_ff == hspfd_pkg::IDX_BITS'(hspfd_pkg::DATA_PULSES - 1));

   always_comb begin
      phase_in           = phase_ff;
      idx_in             = idx_ff;
      held_in            = held_ff;
      shifter_in         = shifter_ff;
      timeout_in         = timeout_ff;
      result.produce     = 1'b0;
      result.frame_bytes = '0;
      result.status      = hspfd_pkg::STATUS_OK;
      if (item.operation == hspfd_pkg::OP_START) begin
         shifter_in = '0;
         timeout_in = 1'b0;
         idx_in     = '0;
         if (!item.line_level) begin
            phase_in       = hspfd_pkg::PH_IDLE;
            result.produce = 1'b1;
            result.status  = hspfd_pkg::STATUS_NOT_READY;
         end else begin
            phase_in = hspfd_pkg::PH_RESP_LOW;
         end
      end else begin
         case (phase_ff)
            hspfd_pkg::PH_RESP_LOW, hspfd_pkg::PH_RESP_HIGH: begin
               if (width_zero) begin
                  phase_in       = hspfd_pkg::PH_IDLE;
                  result.produce = 1'b1;
                  result.status  = hspfd_pkg::STATUS_RESPONSE_TIMEOUT;
               end else if (phase_ff == hspfd_pkg::PH_RESP_LOW) begin
                  phase_in = hspfd_pkg::PH_RESP_HIGH;
               end else begin
                  phase_in = hspfd_pkg::PH_DATA;
                  idx_in   = '0;
               end
            end
            hspfd_pkg::PH_DATA: begin
               timeout_in = timeout_ff | width_zero;
               if (!idx_ff[0]) begin
                  held_in = width;
               end else begin
                  shifter_in = {shifter_ff[hspfd_pkg::DATA_BITS-2:0], (width > held_ff)};
               end
               if (last_pulse) begin
                  phase_in       = hspfd_pkg::PH_IDLE;
                  result.produce = 1'b1;
                  if (timeout_in) begin
                     result.status = hspfd_pkg::STATUS_BIT_TIMEOUT;
                  end else begin
                     result.frame_bytes = shifter_in;
                     result.status      = hspfd_pkg::checksum_ok(shifter_in)
                                        ? hspfd_pkg::STATUS_OK : hspfd_pkg::STATUS_CHECKSUM;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            default: begin
               phase_in = hspfd_pkg::PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= hspfd_pkg::PH_IDLE;
         idx_ff     <= '0;
         shifter_ff <= '0;
         timeout_ff <= 1'b0;
      end else if (process) begin
         phase_ff   <= phase_in;
         idx_ff     <= idx_in;
         shifter_ff <= shifter_in;
         timeout_ff <= timeout_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         held_ff <= held_in;
      end
   end

endmodule

// ===== src/humidity_sensor_pulse_frame_decoder.sv =====
// Channel   Direction  Word
// req_bus   in         operation, line_level, pulse_count
// rsp_bus   out        frame_bytes, status
//
// One word per cycle unless the input register stalls: the input register feeds the decode logic,
// the result register holds the status word. rsp valid rises as the result register is loaded.
// Reset is synchronous and returns the decoder to idle with cleared data bits.
// A word that produces a result stalls in the input register only while the result register
// is full and not being taken; words that produce no result never stall.
module humidity_sensor_pulse_frame_decoder (
   input logic        clock,
   input logic        reset,
   hspfd_req_if.sink   req_bus,
   hspfd_rsp_if.source rsp_bus
);

   logic                                in_valid_ff, in_valid_in;
   hspfd_pkg::item_type                 in_item_ff;
   logic                                out_valid_ff, out_valid_in;
   logic [hspfd_pkg::DATA_BITS-1:0]     out_bytes_ff;
   hspfd_pkg::status_type               out_status_ff;
   hspfd_pkg::result_type               result;
   logic                                out_free;
   logic                                process;
   logic                                req_take;

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign process       = in_valid_ff && (!result.produce || out_free);
   assign req_bus.ready = !in_valid_ff || process;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign in_valid_in   = req_take || (in_valid_ff && !process);
   assign out_valid_in  = (process && result.produce) || (out_valid_ff && !rsp_bus.ready);

   hspfd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .item    (in_item_ff),
      .process (process),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.operation   <= req_bus.operation;
         in_item_ff.line_level  <= req_bus.line_level;
         in_item_ff.pulse_count <= req_bus.pulse_count;
      end
      if (process && result.produce) begin
         out_bytes_ff  <= result.frame_bytes;
         out_status_ff <= result.status;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.frame_bytes = out_bytes_ff;
   assign rsp_bus.status      = out_status_ff;

   a_stall_only_on_result: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !process |-> result.produce && out_valid_ff && !rsp_bus.ready)
      else $error("input word stalled without a pending result");

   a_zero_bytes_on_fault: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_status_ff == hspfd_pkg::STATUS_NOT_READY ||
                       out_status_ff == hspfd_pkg::STATUS_RESPONSE_TIMEOUT ||
                       out_status_ff == hspfd_pkg::STATUS_BIT_TIMEOUT)
      |-> out_bytes_ff == '0)
      else $error("fault status carries frame bytes");

   a_ok_matches_checksum: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff == hspfd_pkg::STATUS_OK
      |-> hspfd_pkg::checksum_ok(out_bytes_ff))
      else $error("ok status with bad checksum");

   a_result_captured: assert property (@(posedge clock) disable iff (reset)
      process && result.produce |=> out_valid_ff && out_status_ff == $past(result.status))
      else $error("result word not captured");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int DRAIN_CYCLES     = 10;
   localparam int PHASE_IDLE       = 0;
   localparam int PHASE_RESP_LOW   = 1;
   localparam int PHASE_RESP_HIGH  = 2;
   localparam int PHASE_FIRST_DATA = 3;

   typedef struct {
      logic [hspfd_pkg::DATA_BITS-1:0] frame_bytes;
      hspfd_pkg::status_type           status;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hspfd_req_if req_if ();
   hspfd_rsp_if rsp_if ();

   humidity_sensor_pulse_frame_decoder uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   always #1 clock = ~clock;

   reading_type          expected_readings[$];
   int                   error_count   = 0;
   int                   words_sent    = 0;
   int                   readings_seen = 0;
   int                   cycle_count   = 0;
   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;

   int                               sensor_phase;
   logic [hspfd_pkg::PULSE_BITS-1:0] held_low;
   logic [hspfd_pkg::DATA_BITS-1:0]  shifter;
   logic                             saw_zero;

   task automatic post_reading(input logic [hspfd_pkg::DATA_BITS-1:0] frame_bytes,
                               input hspfd_pkg::status_type status);
      reading_type r;
      r.frame_bytes = frame_bytes;
      r.status      = status;
      expected_readings.push_back(r);
      sensor_phase = PHASE_IDLE;
   endtask

   task automatic decode_word(input logic op, input logic level,
                              input logic [hspfd_pkg::PULSE_BITS-1:0] raw);
      logic [hspfd_pkg::PULSE_BITS-1:0]  w;
      logic [hspfd_pkg::BYTE_BITS+1:0]   sum;
      int                                slot;
      w = raw & hspfd_pkg::PULSE_BITS'((64'd1 << hspfd_pkg::WIDTH_BITS) - 1);
      if (op == hspfd_pkg::OP_START) begin
         shifter  = '0;
         saw_zero = 1'b0;
         if (!level) begin
            post_reading('0, hspfd_pkg::STATUS_NOT_READY);
         end else begin
            sensor_phase = PHASE_RESP_LOW;
         end
      end else if (sensor_phase == PHASE_RESP_LOW || sensor_phase == PHASE_RESP_HIGH) begin
         if (w == 0) begin
            post_reading('0, hspfd_pkg::STATUS_RESPONSE_TIMEOUT);
         end else begin
            sensor_phase++;
         end
      end else if (sensor_phase < PHASE_FIRST_DATA
                   || sensor_phase >= PHASE_FIRST_DATA + hspfd_pkg::DATA_PULSES) begin
         sensor_phase = PHASE_IDLE;
      end else begin
         slot = sensor_phase - PHASE_FIRST_DATA;
         if (w == 0) saw_zero = 1'b1;
         if (slot % 2 == 0) begin
            held_low = w;
         end else begin
            shifter = {shifter[hspfd_pkg::DATA_BITS-2:0], (w > held_low)};
         end
         if (slot == hspfd_pkg::DATA_PULSES - 1) begin
            if (saw_zero) begin
               post_reading('0, hspfd_pkg::STATUS_BIT_TIMEOUT);
            end else begin
               sum = {2'b00, shifter[39:32]} + {2'b00, shifter[31:24]}
                   + {2'b00, shifter[23:16]} + {2'b00, shifter[15:8]};
               post_reading(shifter,
                            (sum[hspfd_pkg::BYTE_BITS-1:0] == shifter[hspfd_pkg::BYTE_BITS-1:0])
                            ? hspfd_pkg::STATUS_OK : hspfd_pkg::STATUS_CHECKSUM);
            end
         end else begin
            sensor_phase++;
         end
      end
   endtask

   initial begin
      sensor_phase = PHASE_IDLE;
      held_low     = '0;
      shifter      = '0;
      saw_zero     = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         decode_word(req_if.operation, req_if.line_level, req_if.pulse_count);
   end

   always @(posedge clock) begin : check_readings
      reading_type exp;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         readings_seen++;
         if (expected_readings.size() == 0) begin
            $display("%0t: unexpected word frame_bytes=%h status=%0d", $time,
                     rsp_if.frame_bytes, rsp_if.status);
            error_count++;
         end else begin
            exp = expected_readings.pop_front();
            if (rsp_if.frame_bytes !== exp.frame_bytes) begin
               $display("%0t: frame_bytes expected %h actual %h", $time,
                        exp.frame_bytes, rsp_if.frame_bytes);
               error_count++;
            end
            if (rsp_if.status !== exp.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        exp.status, rsp_if.status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic send_word(input logic op, input logic level,
                            input logic [hspfd_pkg::PULSE_BITS-1:0] width);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.operation   <= op;
      req_if.line_level  <= level;
      req_if.pulse_count <= width;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      words_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
   endtask

   function automatic logic [hspfd_pkg::PULSE_BITS-1:0] pick_width(input bit wide);
      if (wide || $urandom_range(0, 49) == 0)
         return hspfd_pkg::PULSE_BITS'($urandom_range(1, 65535));
      return hspfd_pkg::PULSE_BITS'($urandom_range(1, 120));
   endfunction

   task automatic test_not_ready();
      send_word(hspfd_pkg::OP_START, 1'b0, 16'hFFFF);
      send_word(hspfd_pkg::OP_START, 1'b0, 16'h0000);
   endtask

   task automatic test_idle_pulse();
      send_word(hspfd_pkg::OP_PULSE, 1'b1, 16'h0000);
      send_word(hspfd_pkg::OP_PULSE, 1'b0, 16'hFFFF);
   endtask

   task automatic test_response_timeout();
      send_word(hspfd_pkg::OP_START, 1'b1, 16'h0000);
      send_word(hspfd_pkg::OP_PULSE, 1'b0, 16'h0000);
      send_word(hspfd_pkg::OP_START, 1'b1, 16'hFFFF);
      send_word(hspfd_pkg::OP_PULSE, 1'b1, 16'hFFFF);
      send_word(hspfd_pkg::OP_PULSE, 1'b1, 16'h0000);
   endtask

   task automatic test_restart();
      send_word(hspfd_pkg::OP_START, 1'b1, 16'h1234);
      send_word(hspfd_pkg::OP_PULSE, 1'b0, 16'd5);
      send_word(hspfd_pkg::OP_PULSE, 1'b1, 16'd7);
      send_word(hspfd_pkg::OP_PULSE, 1'b0, 16'd3);
      send_word(hspfd_pkg::OP_START, 1'b0, 16'h8000);
      send_word(hspfd_pkg::OP_START, 1'b1, 16'd1);
      send_word(hspfd_pkg::OP_PULSE, 1'b1, 16'd10);
      send_word(hspfd_pkg::OP_START, 1'b1, 16'd2);
      send_word(hspfd_pkg::OP_PULSE, 1'b0, 16'h0000);
   endtask

   task automatic send_frame(input bit good_sum, input bit inject_zero, input bit wide);
      logic [hspfd_pkg::DATA_BITS-1:0]  frame_bytes;
      logic [hspfd_pkg::PULSE_BITS-1:0] lo;
      logic [hspfd_pkg::PULSE_BITS-1:0] hi;
      int                               zero_at;
      int                               p;
      frame_bytes[39:8] = $urandom;
      frame_bytes[7:0]  = good_sum
                        ? hspfd_pkg::BYTE_BITS'(frame_bytes[39:32] + frame_bytes[31:24]
                                                + frame_bytes[23:16] + frame_bytes[15:8])
                        : hspfd_pkg::BYTE_BITS'($urandom);
      zero_at = inject_zero ? int'($urandom_range(0, hspfd_pkg::DATA_PULSES - 1)) : -1;
      send_word(hspfd_pkg::OP_START, 1'b1, hspfd_pkg::PULSE_BITS'($urandom));
      send_word(hspfd_pkg::OP_PULSE, 1'($urandom_range(0, 1)), pick_width(wide));
      send_word(hspfd_pkg::OP_PULSE, 1'($urandom_range(0, 1)), pick_width(wide));
      for (int b = hspfd_pkg::DATA_BITS - 1; b >= 0; b--) begin
         p  = 2 * (hspfd_pkg::DATA_BITS - 1 - b);
         lo = pick_width(wide);
         if (frame_bytes[b]) begin
            if (lo == 16'hFFFF) lo = 16'hFFFE;
            hi = (wide || lo > 200)
               ? hspfd_pkg::PULSE_BITS'(lo + 1 + ($urandom % (65535 - lo)))
               : hspfd_pkg::PULSE_BITS'(lo + $urandom_range(1, 60));
         end else begin
            hi = ($urandom_range(0, 3) == 0) ? lo
                                             : hspfd_pkg::PULSE_BITS'($urandom_range(1, lo));
         end
         send_word(hspfd_pkg::OP_PULSE, 1'($urandom_range(0, 1)), (p == zero_at) ? '0 : lo);
         send_word(hspfd_pkg::OP_PULSE, 1'($urandom_range(0, 1)),
                   (p + 1 == zero_at) ? '0 : hi);
      end
   endtask

   task automatic test_random_traffic(input int word_target, input int reading_target);
      int first_words;
      int first_readings;
      int r;
      int n;
      first_words    = words_sent;
      first_readings = readings_seen;
      while (words_sent - first_words < word_target
             || readings_seen - first_readings < reading_target) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            send_frame(1'($urandom_range(0, 1)), $urandom_range(0, 6) == 0,
                       $urandom_range(0, 9) == 0);
         end else if (r < 70) begin
            send_word(hspfd_pkg::OP_START, 1'b0, hspfd_pkg::PULSE_BITS'($urandom));
         end else if (r < 80) begin
            send_word(hspfd_pkg::OP_START, 1'b1, hspfd_pkg::PULSE_BITS'($urandom));
            if ($urandom_range(0, 1))
               send_word(hspfd_pkg::OP_PULSE, 1'($urandom_range(0, 1)), pick_width(1'b1));
            send_word(hspfd_pkg::OP_PULSE, 1'($urandom_range(0, 1)), '0);
         end else if (r < 90) begin
            send_word(hspfd_pkg::OP_START, 1'b1, hspfd_pkg::PULSE_BITS'($urandom));
            n = $urandom_range(1, 60);
            repeat (n)
               send_word(hspfd_pkg::OP_PULSE, 1'($urandom_range(0, 1)),
                         ($urandom_range(0, 9) == 0) ? '0
                                                     : pick_width(1'($urandom_range(0, 1))));
         end else begin
            n = $urandom_range(1, 3);
            repeat (n)
               send_word(hspfd_pkg::OP_PULSE, 1'($urandom_range(0, 1)),
                         hspfd_pkg::PULSE_BITS'($urandom));
         end
      end
   endtask

   initial begin
      req_if.valid       = 1'b0;
      req_if.operation   = hspfd_pkg::OP_START;
      req_if.line_level  = 1'b0;
      req_if.pulse_count = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 10;
      recv_idle_pct = 60;
      test_not_ready();
      test_idle_pulse();
      test_response_timeout();
      test_restart();
      test_random_traffic(380, 0);

      wait_drained();
      send_idle_pct = 60;
      recv_idle_pct = 10;
      test_random_traffic(380, 0);

      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(380, 0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_readings.size() == 0) begin
         $display("TB_OK");
      end else begin
         if (expected_readings.size() != 0)
            $display("%0t: %0d expected words never arrived", $time, expected_readings.size());
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

// ===== humidity_sensor_pulse_frame_decoder.f =====
src/hspfd_pkg.sv
src/hspfd_req_if.sv
src/hspfd_rsp_if.sv
src/hspfd_core.sv
src/humidity_sensor_pulse_frame_decoder.sv
tb/tb_top.sv
